>>> src/lfuc_pkg.sv
// Shared constants and types for the LFU cache table.
package lfuc_pkg;

  localparam int KEY_W           = 32;
  localparam int VAL_W           = 32;
  localparam int CNT_W           = 32;
  localparam int CAP_W           = 5;
  localparam int ENTRIES_DEFAULT = 16;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [CNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [CNT_W-1:0] COUNT_ONE  = 32'd1;
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  typedef enum logic {
    KIND_GET = 1'b0,
    KIND_PUT = 1'b1
  } kind_t;

endpackage

>>> src/lfuc_scan.sv
// Parallel tag match, free-slot pick, occupancy count and LFU/LRU victim select.
module lfuc_scan #(
  parameter int ENTRIES = lfuc_pkg::ENTRIES_DEFAULT,
  parameter int RW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  parameter int OCC_W   = $clog2(ENTRIES + 1)
) (
  input  logic [ENTRIES-1:0]             valid,
  input  logic [lfuc_pkg::KEY_W-1:0]     keys   [ENTRIES],
  input  logic [lfuc_pkg::CNT_W-1:0]     counts [ENTRIES],
  input  logic [RW-1:0]                  ranks  [ENTRIES],
  input  logic [lfuc_pkg::KEY_W-1:0]     lookup_key,
  output logic [ENTRIES-1:0]             hit_oh,
  output logic [ENTRIES-1:0]             free_oh,
  output logic [ENTRIES-1:0]             victim_oh,
  output logic [OCC_W-1:0]               occupied
);
  import lfuc_pkg::*;

  logic seen_free;

  always_comb begin
    seen_free = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_oh[i]  = valid[i] && (keys[i] == lookup_key);
      free_oh[i] = !valid[i] && !seen_free;
      seen_free  = seen_free || !valid[i];
    end
  end

  // Valid ranks are distinct, so exactly one valid entry beats all others.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      victim_oh[i] = valid[i];
      for (int j = 0; j < ENTRIES; j++) begin
        if (j != i && valid[j] &&
            !((counts[i] < counts[j]) ||
              ((counts[i] == counts[j]) && (ranks[i] > ranks[j])))) begin
          victim_oh[i] = 1'b0;
        end
      end
    end
  end

  assign occupied = OCC_W'($countones(valid));

endmodule

>>> src/lfu_cache_table_unit.sv
// Top level of the LFU cache table with LRU tie break.
//
// Requests arrive on the s_axis channel: s_axis_tuser carries the kind
// (get or put), s_axis_tdata the key and the put value. Results leave on
// m_axis: m_axis_tuser holds found and evicted, m_axis_tdata the value read.
// One result is produced for every request, in order.
// A request is registered in the input register, then looked up and applied to
// the table while its result is registered in the result register. One request
// is taken every cycle while the receiver does not stall: the tag match and the
// min-count, oldest-rank select over all entries complete combinationally
// between the input register and the result register.
// If the receiver stalls, the result is held and one more request can wait
// in the input register; s_axis_tready drops only when both are occupied.
// Reset empties the table, drops any pending request or result and sets the
// capacity to its full value. The user must write the capacity register through
// cfg_wen/cfg_wdata only while no request is in flight; the block does not enforce it.
module lfu_cache_table_unit #(
  parameter int ENTRIES = lfuc_pkg::ENTRIES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [lfuc_pkg::CAP_W-1:0]    cfg_wdata,     // capacity_in_use
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [63:0]                   s_axis_tdata,  // lookup_key, put_value
  input  logic [0:0]                    s_axis_tuser,  // kind
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,  // read_value
  output logic [1:0]                    m_axis_tuser   // found, evicted
);
  import lfuc_pkg::*;

  localparam int RW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  logic [CAP_W-1:0] capacity;

  // Input register.
  logic             req_valid;
  kind_t            req_kind;
  logic [KEY_W-1:0] req_key;
  logic [VAL_W-1:0] req_value;

  // Table.
  logic [ENTRIES-1:0] valid;
  logic [KEY_W-1:0]   keys   [ENTRIES];
  logic [VAL_W-1:0]   values [ENTRIES];
  logic [CNT_W-1:0]   counts [ENTRIES];
  logic [RW-1:0]      ranks  [ENTRIES];

  logic [ENTRIES-1:0] hit_oh, free_oh, victim_oh, slot_oh;
  logic [OCC_W-1:0]   occupied;

  logic             advance;
  logic [CMP_W-1:0] cap_eff;
  logic             full, cap_zero, hit_any;
  logic             do_touch, do_insert, ins_evict, free_insert;
  logic [RW-1:0]    rank_sel;
  logic [VAL_W-1:0] hit_value;
  logic [VAL_W-1:0] read_value_next;

  lfuc_scan #(
    .ENTRIES (ENTRIES),
    .RW      (RW),
    .OCC_W   (OCC_W)
  ) u_scan (
    .valid      (valid),
    .keys       (keys),
    .counts     (counts),
    .ranks      (ranks),
    .lookup_key (req_key),
    .hit_oh     (hit_oh),
    .free_oh    (free_oh),
    .victim_oh  (victim_oh),
    .occupied   (occupied)
  );

  assign advance       = req_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !req_valid || advance;

  always_comb begin
    cap_eff = (CMP_W'(capacity) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(capacity);
    full        = CMP_W'(occupied) >= cap_eff;
    cap_zero    = (capacity == '0);
    hit_any     = |hit_oh;
    do_touch    = hit_any && ((req_kind == KIND_GET) || !cap_zero);
    do_insert   = (req_kind == KIND_PUT) && !cap_zero && !hit_any;
    ins_evict   = do_insert && full;
    free_insert = do_insert && !full;

    if (do_touch) begin
      slot_oh = hit_oh;
    end else if (ins_evict) begin
      slot_oh = victim_oh;
    end else if (do_insert) begin
      slot_oh = free_oh;
    end else begin
      slot_oh = '0;
    end

    rank_sel  = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_oh[i]) rank_sel = rank_sel | ranks[i];
      if (hit_oh[i])  hit_value = hit_value | values[i];
    end

    if (req_kind == KIND_GET) begin
      read_value_next = hit_any ? hit_value : MISS_VALUE;
    end else begin
      read_value_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= CAP_RESET;
      req_valid     <= 1'b0;
      m_axis_tvalid <= 1'b0;
      valid         <= '0;
    end else begin
      if (cfg_wen) capacity <= cfg_wdata;
      if (s_axis_tready) req_valid <= s_axis_tvalid;
      if (advance) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (advance && do_insert) valid <= valid | slot_oh;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      req_kind  <= kind_t'(s_axis_tuser[0]);
      req_key   <= s_axis_tdata[31:0];
      req_value <= s_axis_tdata[63:32];
    end
    if (advance) begin
      m_axis_tdata    <= read_value_next;
      m_axis_tuser[0] <= hit_any;
      m_axis_tuser[1] <= ins_evict;
    end
  end

  // Hit or new entry becomes newest; younger ones (all on a free insert) age by one.
  always_ff @(posedge clk) begin
    if (advance && (do_touch || do_insert)) begin
      for (int j = 0; j < ENTRIES; j++) begin
        if (slot_oh[j]) begin
          ranks[j] <= '0;
          if (do_insert) begin
            keys[j]   <= req_key;
            values[j] <= req_value;
            counts[j] <= COUNT_ONE;
          end else begin
            if (req_kind == KIND_PUT) values[j] <= req_value;
            if (counts[j] != COUNT_MAX) counts[j] <= counts[j] + COUNT_ONE;
          end
        end else if (valid[j] && (free_insert || (ranks[j] < rank_sel))) begin
          ranks[j] <= ranks[j] + RW'(1);
        end
      end
    end
  end

endmodule

>>> tb/sv/lfu_cache_table_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the LFU cache table unit: directed cases, random traffic, back pressure.
module lfu_cache_table_unit_tb;
  import lfuc_pkg::*;

  localparam int NUM_ENTRIES = ENTRIES_DEFAULT;
  localparam int RANK_W      = $clog2(NUM_ENTRIES);
  localparam int POOL_SIZE   = 24;
  localparam int QUIET_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] value;
    logic             evicted;
  } lookup_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wen = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [63:0]      s_axis_tdata = '0;   // lookup_key, put_value
  logic [0:0]       s_axis_tuser = '0;   // kind
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [31:0]      m_axis_tdata;        // read_value
  logic [1:0]       m_axis_tuser;        // found, evicted

  lfu_cache_table_unit #(
    .ENTRIES(NUM_ENTRIES)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the cache table
  logic              tbl_valid [NUM_ENTRIES];
  logic [KEY_W-1:0]  tbl_key   [NUM_ENTRIES];
  logic [VAL_W-1:0]  tbl_val   [NUM_ENTRIES];
  logic [CNT_W-1:0]  tbl_cnt   [NUM_ENTRIES];
  logic [RANK_W-1:0] tbl_rank  [NUM_ENTRIES];
  logic [CAP_W-1:0]  tbl_capacity;

  lookup_result_t    pending_results [$];
  logic [KEY_W-1:0]  key_pool [POOL_SIZE];

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;
  int mismatches     = 0;
  int request_count  = 0;
  int hit_count      = 0;
  int evict_count    = 0;
  int cap_writes     = 0;

  // Make entry i most recent and bump its use count
  function automatic void touch_entry(int i);
    logic [RANK_W-1:0] r;
    r = tbl_rank[i];
    for (int j = 0; j < NUM_ENTRIES; j++)
      if (tbl_valid[j] && j != i && tbl_rank[j] < r) tbl_rank[j] = tbl_rank[j] + 1'b1;
    tbl_rank[i] = '0;
    if (tbl_cnt[i] != COUNT_MAX) tbl_cnt[i] = tbl_cnt[i] + 1'b1;
  endfunction

  function automatic lookup_result_t cache_predict(kind_t kind, logic [KEY_W-1:0] key,
                                                   logic [VAL_W-1:0] val);
    lookup_result_t    res;
    int                cap, occupied, hit, free_slot, victim, slot;
    logic [RANK_W-1:0] r;
    res       = '0;
    cap       = (tbl_capacity > NUM_ENTRIES) ? NUM_ENTRIES : int'(tbl_capacity);
    occupied  = 0;
    hit       = -1;
    free_slot = -1;
    victim    = -1;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (tbl_valid[i]) begin
        occupied++;
        if (tbl_key[i] == key) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (kind == KIND_GET) begin
      if (hit >= 0) begin
        res.value = tbl_val[hit];
        touch_entry(hit);
      end else begin
        res.value = MISS_VALUE;
      end
    end else if (cap != 0) begin
      if (hit >= 0) begin
        tbl_val[hit] = val;
        touch_entry(hit);
      end else begin
        // lowest count wins, oldest among equals
        if (occupied >= cap)
          for (int i = 0; i < NUM_ENTRIES; i++)
            if (tbl_valid[i] && (victim < 0 || tbl_cnt[i] < tbl_cnt[victim] ||
                (tbl_cnt[i] == tbl_cnt[victim] && tbl_rank[i] > tbl_rank[victim])))
              victim = i;
        if (victim >= 0) begin
          r = tbl_rank[victim];
          tbl_valid[victim] = 1'b0;
          for (int j = 0; j < NUM_ENTRIES; j++)
            if (tbl_valid[j] && tbl_rank[j] > r) tbl_rank[j] = tbl_rank[j] - 1'b1;
          res.evicted = 1'b1;
          slot = victim;
        end else begin
          slot = free_slot;
        end
        if (slot >= 0) begin
          for (int j = 0; j < NUM_ENTRIES; j++)
            if (tbl_valid[j]) tbl_rank[j] = tbl_rank[j] + 1'b1;
          tbl_valid[slot] = 1'b1;
          tbl_key[slot]   = key;
          tbl_val[slot]   = val;
          tbl_cnt[slot]   = COUNT_ONE;
          tbl_rank[slot]  = '0;
        end
      end
    end
    res.found = (hit >= 0);
    return res;
  endfunction

  task automatic send_request(kind_t kind, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
    lookup_result_t res;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {val, key};
    do @(posedge clk); while (!s_axis_tready);
    res = cache_predict(kind, key, val);
    pending_results.push_back(res);
    request_count++;
    if (res.found) hit_count++;
    if (res.evicted) evict_count++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] cap);
    drain_results();
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    tbl_capacity = cap;
    cap_writes++;
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Compare each result against the oldest prediction
  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: found=%0b value=%h evicted=%0b",
                   m_axis_tuser[0], m_axis_tdata, m_axis_tuser[1]);
      end else begin
        want = pending_results.pop_front();
        if (want.found !== m_axis_tuser[0] || want.value !== m_axis_tdata ||
            want.evicted !== m_axis_tuser[1]) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: exp found=%0b value=%h evicted=%0b, got found=%0b value=%h evicted=%0b",
                     want.found, want.value, want.evicted,
                     m_axis_tuser[0], m_axis_tdata, m_axis_tuser[1]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_basic_ops();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_request(KIND_GET, 32'h8000_0000, 32'h0);
    send_request(KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(KIND_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(KIND_PUT, 32'h8000_0000, 32'h0);
    send_request(KIND_GET, 32'hFFFF_FFFF, 32'h1234_5678);
    drain_results();
  endtask

  // Equal counts evict the oldest; a higher count survives
  task automatic test_tie_break();
    set_capacity(5'd2);
    send_request(KIND_PUT, 32'd10, 32'd100);
    send_request(KIND_PUT, 32'd20, 32'd200);
    send_request(KIND_PUT, 32'd30, 32'd300);
    send_request(KIND_GET, 32'd20, 32'd0);
    send_request(KIND_PUT, 32'd40, 32'd400);
    send_request(KIND_GET, 32'd10, 32'd0);
    drain_results();
  endtask

  // Zero capacity: puts are dropped, gets still hit
  task automatic test_capacity_zero();
    set_capacity(5'd0);
    send_request(KIND_PUT, 32'd20, 32'd5);
    send_request(KIND_PUT, 32'd99, 32'd9);
    send_request(KIND_GET, 32'd20, 32'd0);
    send_request(KIND_GET, 32'd99, 32'd0);
    drain_results();
  endtask

  // Shrink below occupancy, then capacity above the table size
  task automatic test_capacity_limits();
    set_capacity(5'd1);
    send_request(KIND_PUT, 32'd50, 32'd500);
    send_request(KIND_GET, 32'd20, 32'd0);
    set_capacity(5'd31);
    send_request(KIND_PUT, 32'd60, 32'hFFFF_FFFF);
    send_request(KIND_GET, 32'd60, 32'd0);
    drain_results();
  endtask

  task automatic test_random_traffic(int count, logic [CAP_W-1:0] cap, int src_pct,
                                     int sink_pct);
    int               span;
    kind_t            kind;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    set_capacity(cap);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    span = ((cap > NUM_ENTRIES) ? NUM_ENTRIES : int'(cap)) + 6;
    for (int n = 0; n < count; n++) begin
      key  = ($urandom_range(99) < 88) ? key_pool[$urandom_range(span - 1)] : $urandom();
      val  = $urandom();
      if ($urandom_range(15) == 0) val = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      kind = kind_t'($urandom_range(1));
      send_request(kind, key, val);
      // read back a fresh put now and then
      if (kind == KIND_PUT && $urandom_range(3) == 0) begin
        send_request(KIND_GET, key, $urandom());
        n++;
      end
    end
    drain_results();
  endtask

  // Hold off the receiver while requests keep coming, so the input stalls
  task automatic test_backpressure();
    set_capacity(5'd16);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    @(posedge clk);
    hold_left = 120;
    for (int n = 0; n < 40; n++)
      send_request(kind_t'($urandom_range(1)), key_pool[$urandom_range(POOL_SIZE - 1)],
                   $urandom());
    drain_results();
  endtask

  initial begin
    for (int i = 0; i < NUM_ENTRIES; i++) tbl_valid[i] = 1'b0;
    tbl_capacity = CAP_RESET;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    key_pool[4] = 32'h0000_0001;
    for (int i = 5; i < POOL_SIZE; i++) key_pool[i] = $urandom();

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_basic_ops();
    test_tie_break();
    test_capacity_zero();
    test_capacity_limits();
    test_random_traffic(250, 5'd16, 0, 0);
    test_random_traffic(200, 5'd4, 74, 0);
    test_random_traffic(200, 5'd31, 0, 74);
    test_random_traffic(150, 5'd1, 13, 13);
    test_random_traffic(100, 5'd0, 0, 0);
    test_random_traffic(200, 5'd17, 13, 13);
    test_random_traffic(150, 5'd9, 0, 0);
    test_backpressure();

    mismatches += pending_results.size();
    $display("Covered %0d requests with %0d hits and %0d evictions over %0d capacity writes",
             request_count, hit_count, evict_count, cap_writes);
    $display("Idle mixes: none, sender 74%%, receiver 74%%, both 13%%, plus a long receiver hold-off");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
